FILE: hdl/pfe_pkg.sv
// package for the postfix expression evaluator
// token codes, status codes and the front-to-back request type; no dependencies
`timescale 1ns / 1ps
package pfe_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_ILL  = 3'd5,
    OP_END  = 3'd6,
    OP_RSV  = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_ILLEGAL  = 3'd3,
    ST_TOO_MANY = 3'd4,
    ST_EXPR_ERR = 3'd5,
    ST_OVERFLOW = 3'd6,
    ST_UNUSED   = 3'd7
  } status_e;

  // classified token handed from the front to the back
  typedef struct packed {
    opcode_e     op;
    logic [31:0] num;
  } token_t;

endpackage

FILE: hdl/pfe_if.sv
// valid/ready channel interfaces for tokens and results
// depends on nothing
`timescale 1ns / 1ps
interface pfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [31:0] number_value;
  modport source (output valid, opcode, number_value, input ready);
  modport sink (input valid, opcode, number_value, output ready);
endinterface

interface pfe_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [2:0]  status;
  logic        is_final;
  modport source (output valid, result_value, status, is_final, input ready);
  modport sink (input valid, result_value, status, is_final, output ready);
endinterface

FILE: hdl/pfe_ram.sv
// generic single-port-write, one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module pfe_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/pfe_queue.sv
// two-entry token queue between the front and the back
// depends on pfe_pkg
`timescale 1ns / 1ps
module pfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfe_pkg::token_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pfe_pkg::token_t data_o
);
  pfe_pkg::token_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underrun");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
endmodule

FILE: hdl/pfe_front.sv
// front end: accepts tokens, folds the reserved opcode onto illegal, queues them
// depends on pfe_pkg and pfe_in_if
`timescale 1ns / 1ps
module pfe_front (
  pfe_in_if.sink          in_if,
  input  logic            q_full_i,
  output logic            q_push_o,
  output pfe_pkg::token_t q_data_o
);
  pfe_pkg::opcode_e op;

  always_comb begin
    op = pfe_pkg::opcode_e'(in_if.opcode);
    unique case (op)
      pfe_pkg::OP_RSV: op = pfe_pkg::OP_ILL;
      default:         ;
    endcase
  end

  assign in_if.ready   = !q_full_i;
  assign q_push_o      = in_if.valid && !q_full_i;
  assign q_data_o.op   = op;
  assign q_data_o.num  = in_if.number_value;
endmodule

FILE: hdl/pfe_back.sv
// back end: stack machine over the operand ram with a serial fixed-point divider
// depends on pfe_pkg, pfe_ram and pfe_out_if
`timescale 1ns / 1ps
module pfe_back #(
  parameter int StackDepth   = 128,
  parameter int FractionBits = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  pfe_pkg::token_t q_data_i,
  output logic            q_pop_o,
  pfe_out_if.source       out_if
);
  localparam int AW = $clog2(StackDepth);
  localparam int CW = $clog2(StackDepth + 1);
  localparam int NW = 32 + FractionBits; // scaled dividend magnitude width
  localparam int DC = $clog2(NW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RDB, S_RDA, S_EXEC, S_MUL, S_DIV, S_DONE
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic              disc_q;
  pfe_pkg::opcode_e  op_q;
  logic [31:0]       b_q;
  logic [31:0]       a_q;
  logic signed [63:0] prod_q;
  logic [NW-1:0]     quo_q;
  logic [32:0]       rem_q;
  logic [31:0]       dvs_q;
  logic              neg_q;
  logic [DC-1:0]     dcnt_q;
  logic [31:0]       res_q;

  logic              out_v_q;
  logic [31:0]       out_val_q;
  pfe_pkg::status_e  out_st_q;
  logic              out_fin_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [31:0]       wdata, rdata;

  pfe_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // operand magnitudes for the divider
  logic [31:0] mag_a, mag_b;
  assign mag_a = a_q[31] ? 32'(-a_q) : a_q;
  assign mag_b = b_q[31] ? 32'(-b_q) : b_q;

  // next divider step: shift in one dividend bit, subtract when it fits
  logic [32:0] rem_sh;
  logic        fits;
  assign rem_sh = {rem_q[31:0], quo_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  logic signed [65:0] sum_ext, diff_ext, mul_ext, div_ext;
  logic signed [63:0] mul_rnd;
  assign sum_ext  = 66'(signed'(a_q)) + 66'(signed'(b_q));
  assign diff_ext = 66'(signed'(a_q)) - 66'(signed'(b_q));
  always_comb begin
    mul_rnd = prod_q;
    if (FractionBits > 0) mul_rnd = prod_q + (64'sd1 <<< (FractionBits - 1));
  end
  assign mul_ext = 66'(mul_rnd >>> FractionBits);
  assign div_ext = neg_q ? -66'(signed'({1'b0, quo_q})) : 66'(signed'({1'b0, quo_q}));

  logic top_ok;
  assign top_ok = cnt_q >= CW'(2);

  // ram addressing: read the top at dispatch, the next one the cycle after
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = q_data_i.num;
    raddr = AW'(cnt_q - CW'(1));
    if (q_pop_o && !disc_q && q_data_i.op == pfe_pkg::OP_PUSH
        && cnt_q < CW'(StackDepth)) begin
      we = 1'b1;
    end
    if (state_q == S_IDLE && q_data_i.op == pfe_pkg::OP_END) raddr = '0;
    if (state_q == S_RDB) raddr = AW'(cnt_q - CW'(2));
    if (state_q == S_DONE) begin
      we    = 1'b1;
      waddr = AW'(cnt_q - CW'(2));
      wdata = res_q;
    end
  end

  assign q_pop_o        = state_q == S_IDLE && !q_empty_i && !out_v_q;
  assign out_if.valid   = out_v_q;
  assign out_if.result_value = out_val_q;
  assign out_if.status  = out_st_q;
  assign out_if.is_final = out_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      disc_q    <= 1'b0;
      out_v_q   <= 1'b0;
      op_q      <= pfe_pkg::OP_PUSH;
      out_st_q  <= pfe_pkg::ST_OK;
      out_fin_q <= 1'b0;
      out_val_q <= '0;
      dcnt_q    <= '0;
    end else begin
      if (out_v_q && out_if.ready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            op_q <= q_data_i.op;
            if (q_data_i.op == pfe_pkg::OP_END) begin
              out_val_q <= '0;
              out_fin_q <= 1'b1;
              out_st_q  <= (disc_q || cnt_q == '0) ? pfe_pkg::ST_EXPR_ERR :
                           (cnt_q == CW'(1)) ? pfe_pkg::ST_OK : pfe_pkg::ST_TOO_MANY;
              disc_q    <= 1'b0;
              if (!disc_q && cnt_q == CW'(1)) state_q <= S_RDB;
              else begin
                out_v_q <= 1'b1;
                cnt_q   <= '0;
              end
            end else if (!disc_q) begin
              out_val_q <= '0;
              out_fin_q <= 1'b0;
              if (q_data_i.op == pfe_pkg::OP_PUSH) begin
                if (cnt_q < CW'(StackDepth)) cnt_q <= cnt_q + CW'(1);
                else begin
                  out_st_q <= pfe_pkg::ST_OVERFLOW;
                  out_v_q  <= 1'b1;
                  disc_q   <= 1'b1;
                end
              end else if (!top_ok) begin
                out_st_q <= pfe_pkg::ST_FEW;
                out_v_q  <= 1'b1;
                disc_q   <= 1'b1;
                cnt_q    <= '0;
              end else begin
                state_q <= S_RDB;
              end
            end
          end
        end
        S_RDB: begin
          if (op_q == pfe_pkg::OP_END) begin
            // single operand final value
            out_val_q <= rdata;
            out_v_q   <= 1'b1;
            cnt_q     <= '0;
            state_q   <= S_IDLE;
          end else begin
            b_q     <= rdata;
            state_q <= S_RDA;
          end
        end
        S_RDA: begin
          a_q     <= rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_DONE;
          case (op_q)
            pfe_pkg::OP_ADD: res_q <= sat(sum_ext);
            pfe_pkg::OP_SUB: res_q <= sat(diff_ext);
            pfe_pkg::OP_MUL: begin
              prod_q  <= 64'(signed'(a_q)) * 64'(signed'(b_q));
              state_q <= S_MUL;
            end
            pfe_pkg::OP_DIV: begin
              if (b_q == '0) begin
                out_st_q <= pfe_pkg::ST_DIV_ZERO;
                out_v_q  <= 1'b1;
                disc_q   <= 1'b1;
                cnt_q    <= cnt_q - CW'(2);
                state_q  <= S_IDLE;
              end else begin
                quo_q   <= NW'(mag_a) << FractionBits;
                dvs_q   <= mag_b;
                neg_q   <= a_q[31] ^ b_q[31];
                rem_q   <= '0;
                dcnt_q  <= DC'(NW);
                state_q <= S_DIV;
              end
            end
            default: begin
              out_st_q <= pfe_pkg::ST_ILLEGAL;
              out_v_q  <= 1'b1;
              disc_q   <= 1'b1;
              cnt_q    <= cnt_q - CW'(2);
              state_q  <= S_IDLE;
            end
          endcase
        end
        S_MUL: begin
          res_q   <= sat(mul_ext);
          state_q <= S_DONE;
        end
        S_DIV: begin
          if (dcnt_q == '0) begin
            res_q   <= sat(div_ext);
            state_q <= S_DONE;
          end else begin
            rem_q  <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
            quo_q  <= {quo_q[NW-2:0], fits};
            dcnt_q <= dcnt_q - DC'(1);
          end
        end
        S_DONE: begin
          cnt_q   <= cnt_q - CW'(1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(StackDepth)) else $error("stack count past depth");
  a_disc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && q_pop_o && disc_q && q_data_i.op != pfe_pkg::OP_END
    |=> $stable(cnt_q)) else $error("discarded token changed stack");
  a_err_sets_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) && !out_fin_q |-> disc_q) else $error("error without discard");
endmodule

FILE: hdl/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator
// depends on pfe_pkg, pfe_if, pfe_front, pfe_queue and pfe_back
`timescale 1ns / 1ps
// Tokens enter on in_if and land in a two-entry queue, so the source sees
// ready while the queue has room. The stack unit handles push and ignored
// tokens in its idle state; add and subtract read both operands, execute and
// write back, multiply also rounds, and divide (Q16.16 by default) forms the
// quotient one bit per cycle. Each error or end token yields one result on
// out_if, held in an output register until taken; the stack unit waits for
// that register to empty before it takes its next token. The operand stack
// sits in a single-write, single-read ram with registered read.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH   = 128,
  parameter int FRACTION_BITS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  pfe_in_if.sink    in_if,
  pfe_out_if.source out_if
);
  logic            q_push, q_full, q_pop, q_empty;
  pfe_pkg::token_t q_wdata, q_rdata;

  pfe_front u_front (
    .in_if, .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_wdata)
  );

  pfe_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_rdata)
  );

  pfe_back #(.StackDepth(STACK_DEPTH), .FractionBits(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_rdata), .q_pop_o(q_pop),
    .out_if
  );
endmodule
